@@ rtl/core/kbc_pkg.sv @@
// ----------------------------------------------------------------------------
// kbc_pkg
// Types, constants and helper functions shared by the k-mer base corrector.
// ----------------------------------------------------------------------------
package kbc_pkg;

    localparam int CNT_W    = 12;
    localparam int SUM_W    = CNT_W + 2;
    localparam int KLEN_W   = 4;
    localparam int RUN_W    = 4;
    localparam int TBL_AW   = 16;
    localparam int CHAR_W   = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef enum logic {
        REG_MIN_COVERAGE = 1'b0,
        REG_KMER_LENGTH  = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_BASE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt_t;
        logic [CNT_W-1:0] cnt_g;
        logic [CNT_W-1:0] cnt_c;
        logic [CNT_W-1:0] cnt_a;
        logic             valid;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
    } tbl_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              corrected;
        logic              failed;
        logic [1:0]        code;
    } dec_result_t;

    localparam logic [CHAR_W-1:0] CHAR_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C  = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G  = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T  = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_LT = 8'h74;

    localparam logic [2:0] CODE_INVALID = 3'd4;

    function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [2:0] code;
        case (ch)
            CHAR_A, CHAR_LA: code = 3'd0;
            CHAR_C, CHAR_LC: code = 3'd1;
            CHAR_G, CHAR_LG: code = 3'd2;
            CHAR_T, CHAR_LT: code = 3'd3;
            default:         code = CODE_INVALID;
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] code_letter(input logic [1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            2'd0:    ch = CHAR_A;
            2'd1:    ch = CHAR_C;
            2'd2:    ch = CHAR_G;
            default: ch = CHAR_T;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/kbc_table.sv @@
// ----------------------------------------------------------------------------
// kbc_table
// Count table memory with one write and one registered read port, and a
// clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module kbc_table
    import kbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output entry_t   rd_data,
    output logic     clearing
);

    entry_t            mem [2**TBL_AW];
    entry_t            rd_data_reg;
    logic              clear_reg;
    logic              clear_next;
    logic [TBL_AW-1:0] clr_addr_reg;
    logic [TBL_AW-1:0] clr_addr_next;
    logic              wr_en;
    logic [TBL_AW-1:0] wr_addr;
    entry_t            wr_data;

    always_comb
    begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        if (clear_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = req.wr_en;
            wr_addr = req.wr_addr;
            wr_data = req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

@@ rtl/core/kbc_decide.sv @@
// ----------------------------------------------------------------------------
// kbc_decide
// Confirms, corrects or fails one base from the counts of its k-mer entry.
// ----------------------------------------------------------------------------
module kbc_decide
    import kbc_pkg::*;
(
    input  entry_t            entry,
    input  logic              check,
    input  logic [CHAR_W-1:0] base_char,
    input  logic [CNT_W-1:0]  min_coverage,
    output dec_result_t       result
);

    logic [CNT_W-1:0]   cnt [4];
    logic [2:0]         code_in;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-2:0]   half;
    logic               own_ok;
    logic [3:0]         cand;
    logic               pick_found;
    logic [1:0]         pick;
    logic [2:0]         code_out;

    always_comb
    begin
        cnt[0]  = entry.cnt_a;
        cnt[1]  = entry.cnt_c;
        cnt[2]  = entry.cnt_g;
        cnt[3]  = entry.cnt_t;
        code_in = base_code(base_char);
        sum     = SUM_W'(cnt[0]) + SUM_W'(cnt[1]) + SUM_W'(cnt[2]) + SUM_W'(cnt[3]);
        half    = sum[SUM_W-1:1];
        own_ok  = !code_in[2] && (cnt[code_in[1:0]] >= min_coverage);
        for (int i = 0; i < 4; i++)
        begin
            cand[i] = ((SUM_W-1)'(cnt[i]) > half) && (cnt[i] >= min_coverage);
        end
        pick_found = |cand;
        if (cand[0])
        begin
            pick = 2'd0;
        end
        else if (cand[1])
        begin
            pick = 2'd1;
        end
        else if (cand[2])
        begin
            pick = 2'd2;
        end
        else
        begin
            pick = 2'd3;
        end

        result.ch        = base_char;
        result.corrected = 1'b0;
        result.failed    = 1'b0;
        code_out         = code_in;
        if (check && entry.valid && !own_ok)
        begin
            if (pick_found)
            begin
                result.corrected = (code_in != {1'b0, pick});
                code_out         = {1'b0, pick};
                result.ch        = code_letter(pick);
            end
            else
            begin
                result.failed = 1'b1;
            end
        end
        if (code_out[2])
        begin
            result.failed = 1'b1;
        end
        result.code = code_out[1:0];
    end

endmodule

@@ rtl/core/kmer_read_base_corrector.sv @@
// ----------------------------------------------------------------------------
// kmer_read_base_corrector
// Corrects read bases one at a time against a table of k-mer next-base
// counts held in a 65536-entry memory.
//
//   Channel   Handshake            Payload
//   -------   ------------------   --------------------------------------------
//   item in   start / busy         opcode, entry_key, count_a..count_t,
//                                  base_char, read_end
//   result    done (strobe)        out_char, was_corrected, base_failed,
//                                  read_last
//   config    write_enable         write_index, write_data
//
// A load beat writes its entry into the table and leaves busy low; a base
// beat has a table read and then a decision, which sets the next lookup key.
// The result of a base beat is registered in the decision state and is on
// the result ports for one cycle only, and cannot be stalled.
// After reset every table entry is swept to invalid; busy stays high until
// the sweep has ended, and configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module kmer_read_base_corrector
    import kbc_pkg::*;
#(
    parameter int MAX_KMER = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [15:0]       entry_key,
    input  logic [CNT_W-1:0]  count_a,
    input  logic [CNT_W-1:0]  count_c,
    input  logic [CNT_W-1:0]  count_g,
    input  logic [CNT_W-1:0]  count_t,
    input  logic [CHAR_W-1:0] base_char,
    input  logic              read_end,
    input  logic              write_enable,
    input  logic              write_index,
    input  logic [CNT_W-1:0]  write_data,
    output logic              done,
    output logic [CHAR_W-1:0] out_char,
    output logic              was_corrected,
    output logic              base_failed,
    output logic              read_last
);

    localparam int WIN_W = 2 * MAX_KMER;
    localparam int KEY_W = (WIN_W > TBL_AW) ? WIN_W : TBL_AW;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   min_cov_reg;
    logic [KLEN_W-1:0]  klen_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [WIN_W-1:0]   window_next;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               end_reg;
    logic               check_reg;
    logic               done_reg;
    logic               done_next;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               corrected_reg;
    logic               failed_reg;
    logic               last_reg;

    logic               accept;
    logic               eval;
    logic [KLEN_W-1:0]  k_eff;
    logic [WIN_W-1:0]   kmask;
    logic [KEY_W-1:0]   key_ext;
    logic [WIN_W+1:0]   win_ext;
    tbl_req_t           tbl_req;
    entry_t             tbl_data;
    logic               clearing;
    dec_result_t        dec;
    entry_t             load_entry;

    kbc_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .rd_data  (tbl_data),
        .clearing (clearing)
    );

    kbc_decide u_decide (
        .entry        (tbl_data),
        .check        (check_reg),
        .base_char    (char_reg),
        .min_coverage (min_cov_reg),
        .result       (dec)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && (opcode == OP_BASE))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        eval      = (state_reg == ST_EVAL);
        accept    = start && !busy;
        done_next = eval;
    end

    always_comb
    begin
        if (klen_reg == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (klen_reg > KLEN_W'(MAX_KMER))
        begin
            k_eff = KLEN_W'(MAX_KMER);
        end
        else
        begin
            k_eff = klen_reg;
        end
        for (int i = 0; i < WIN_W; i++)
        begin
            kmask[i] = ((i >> 1) < int'(k_eff));
        end
        key_ext = KEY_W'(window_reg & kmask);

        load_entry.valid = 1'b1;
        load_entry.cnt_a = count_a;
        load_entry.cnt_c = count_c;
        load_entry.cnt_g = count_g;
        load_entry.cnt_t = count_t;

        tbl_req.wr_en   = accept && (opcode == OP_LOAD);
        tbl_req.wr_addr = entry_key;
        tbl_req.wr_data = load_entry;
        tbl_req.rd_en   = accept && (opcode == OP_BASE);
        tbl_req.rd_addr = key_ext[TBL_AW-1:0];
    end

    always_comb
    begin
        win_ext     = {window_reg, dec.code};
        window_next = window_reg;
        run_next    = run_reg;
        if (eval)
        begin
            if (dec.failed)
            begin
                run_next = '0;
            end
            else
            begin
                window_next = win_ext[WIN_W-1:0];
                if (run_reg != '1)
                begin
                    run_next = run_reg + 1'b1;
                end
            end
            if (end_reg)
            begin
                window_next = '0;
                run_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            min_cov_reg <= CNT_W'(2);
            klen_reg    <= KLEN_W'(8);
            window_reg  <= '0;
            run_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            window_reg <= window_next;
            run_reg    <= run_next;
            done_reg   <= done_next;
            if (write_enable)
            begin
                unique case (reg_idx_t'(write_index))
                    REG_MIN_COVERAGE: min_cov_reg <= write_data;
                    REG_KMER_LENGTH:  klen_reg    <= write_data[KLEN_W-1:0];
                    default:          min_cov_reg <= min_cov_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_BASE))
        begin
            char_reg  <= base_char;
            end_reg   <= read_end;
            check_reg <= (run_reg >= k_eff);
        end
        if (eval)
        begin
            out_char_reg  <= dec.ch;
            corrected_reg <= dec.corrected;
            failed_reg    <= dec.failed;
            last_reg      <= end_reg;
        end
    end

    assign done          = done_reg;
    assign out_char      = out_char_reg;
    assign was_corrected = corrected_reg;
    assign base_failed   = failed_reg;
    assign read_last     = last_reg;

endmodule

@@ rtl/core/kbc_checker.sv @@
// ----------------------------------------------------------------------------
// kbc_checker
// Port-level checks on the base corrector, bound to the top level.
// ----------------------------------------------------------------------------
module kbc_checker
    import kbc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              opcode,
    input logic              done,
    input logic [CHAR_W-1:0] out_char,
    input logic              was_corrected,
    input logic              base_failed
);

    logic base_beat;
    logic load_beat;

    assign base_beat = start && !busy && (opcode == OP_BASE);
    assign load_beat = start && !busy && (opcode == OP_LOAD);

    a_base_result: assert property (@(posedge clk) disable iff (!rst_n)
        base_beat |=> busy ##1 done)
        else $error("Base beat did not give a result two cycles later.");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_beat |=> ##1 !done)
        else $error("Load beat gave a result.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_corr_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_corrected) |-> (!base_failed && (out_char == CHAR_A ||
            out_char == CHAR_C || out_char == CHAR_G || out_char == CHAR_T)))
        else $error("Replaced base is not an uppercase base or is marked failed.");

endmodule

bind kmer_read_base_corrector kbc_checker u_kbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .done          (done),
    .out_char      (out_char),
    .was_corrected (was_corrected),
    .base_failed   (base_failed)
);
